@@ rtl/cpfe_pkg.sv @@
// shared types, widths and codes for the cassette pulse front end
package cpfe_pkg;

    localparam int CNT_W    = 16;
    localparam int TOTAL_W  = CNT_W + 1;
    localparam int PROD_W   = 23;
    localparam int THRESH_W = 12;
    localparam int PERIOD_W = 4;
    localparam int PORT_W   = 8;
    localparam int FACTOR_W = 8;
    localparam int IDX_W    = 2;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int CFG_W     = 16;

    localparam logic [CNT_W-1:0]    CNT_MAX         = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = '1;
    localparam logic [CNT_W-1:0]    TIMEOUT_RST     = 16'd3000;
    localparam logic [CNT_W-1:0]    PERIOD_RST      = 16'd357;
    localparam logic [FACTOR_W-1:0] FACTOR_RST      = 8'd10;
    localparam logic [PORT_W-1:0]   PORT_B_RST      = 8'hff;
    localparam logic [THRESH_W-1:0] BASE_THRESH     = 12'd10;
    localparam logic [PERIOD_W-1:0] FLAG_LEVEL      = 4'd4;
    localparam logic [PERIOD_W-1:0] RESTART_LEVEL   = 4'd8;

    // port b bit roles
    localparam int PB_RESTART = 4;
    localparam int PB_MOTOR   = 6;
    localparam int PB_REWIND  = 7;

    typedef enum logic [1:0] {
        KIND_EAR   = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_PORT  = 2'd3
    } kind_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_PERIOD  = 2'd1,
        REG_FACTOR  = 2'd2,
        REG_NONE    = 2'd3
    } cfg_idx_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the input beat
        logic prod;   // form duty products for a frame strobe
        logic exec;   // update state and load the result register
    } ctl_cmd_t;

endpackage

@@ rtl/cpfe_ctrl.sv @@
// sequencer for the cassette pulse front end: input, product and result handshakes
module cpfe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic [1:0]            s_tuser,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output cpfe_pkg::ctl_cmd_t    cmd
);
    import cpfe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROD,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (kind_t'(s_tuser) == KIND_FRAME) ? ST_PROD : ST_EXEC;
                end
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/cpfe_datapath.sv @@
// state, configuration and result logic of the cassette pulse front end
module cpfe_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cpfe_pkg::ctl_cmd_t              cmd,
    input  logic [cpfe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [cpfe_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            cfg_valid,
    input  logic [cpfe_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cpfe_pkg::CFG_W-1:0]      cfg_data,
    output logic [cpfe_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cpfe_pkg::*;

    // configuration
    logic [CNT_W-1:0]    timeout_reg, period_cfg_reg;
    logic [FACTOR_W-1:0] factor_reg;

    // captured beat
    kind_t             kind_reg;
    logic              ear_reg;
    logic [PORT_W-1:0] pdata_reg, pmask_reg;

    // frame products
    logic [PROD_W-1:0] h100_reg, t41_reg, t60_reg;
    logic              over_reg;

    // block state
    logic [PORT_W-1:0]   port_b_reg, port_b_next;
    logic                last_ear_reg, last_ear_next;
    logic                toggle_reg, toggle_next;
    logic                parity_reg, parity_next;
    logic                seen_reg, seen_next;
    logic [CNT_W-1:0]    since_reg, since_next;
    logic [CNT_W-1:0]    prescale_reg, prescale_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                flag_reg, flag_next;
    logic [CNT_W-1:0]    high_reg, high_next;
    logic [CNT_W-1:0]    low_reg, low_next;
    logic                present_reg, present_next;

    logic [M_TDATA_W-1:0] out_reg;

    logic [TOTAL_W-1:0]  total;
    logic [THRESH_W-1:0] thresh;
    logic                rising, silent, restart;
    logic                par_a, tog_a;
    logic [CNT_W-1:0]    pre_inc;
    logic [PORT_W-1:0]   pb_new;

    assign total  = TOTAL_W'(high_reg) + TOTAL_W'(low_reg);
    assign thresh = port_b_reg[PB_REWIND] ? THRESH_W'(factor_reg) * THRESH_W'(10)
                                          : BASE_THRESH;

    always_comb begin
        port_b_next   = port_b_reg;
        last_ear_next = last_ear_reg;
        toggle_next   = toggle_reg;
        parity_next   = parity_reg;
        seen_next     = seen_reg;
        since_next    = since_reg;
        prescale_next = prescale_reg;
        period_next   = period_reg;
        flag_next     = flag_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        present_next  = present_reg;
        rising        = 1'b0;
        silent        = 1'b0;
        restart       = 1'b0;
        par_a         = 1'b0;
        tog_a         = 1'b0;
        pre_inc       = '0;
        pb_new        = '0;
        unique case (kind_reg)
            KIND_EAR: begin
                last_ear_next = ear_reg;
                if (ear_reg) begin
                    high_next = (high_reg == CNT_MAX) ? CNT_MAX : high_reg + 1'b1;
                end else begin
                    low_next = (low_reg == CNT_MAX) ? CNT_MAX : low_reg + 1'b1;
                end
                rising = !last_ear_reg && ear_reg;
                silent = !seen_reg || (since_reg == CNT_MAX) || (since_reg > timeout_reg);
                if (rising) begin
                    par_a       = silent ? 1'b0 : parity_reg;
                    tog_a       = silent ? 1'b0 : toggle_reg;
                    seen_next   = 1'b1;
                    since_next  = '0;
                    parity_next = !par_a;
                    toggle_next = !par_a ? !tog_a : tog_a;
                end
                restart = !toggle_reg && toggle_next && (period_reg >= RESTART_LEVEL);
            end
            KIND_TICK: begin
                since_next = (since_reg == CNT_MAX) ? CNT_MAX : since_reg + 1'b1;
                pre_inc    = (prescale_reg == CNT_MAX) ? CNT_MAX : prescale_reg + 1'b1;
                if (pre_inc >= period_cfg_reg) begin
                    prescale_next = '0;
                    flag_next     = (period_reg >= FLAG_LEVEL);
                    period_next   = (period_reg == PERIOD_MAX) ? PERIOD_MAX
                                                               : period_reg + 1'b1;
                end else begin
                    prescale_next = pre_inc;
                end
            end
            KIND_FRAME: begin
                if (over_reg) begin
                    // floor(100h/t) in (40,60) is 100h >= 41t and 100h < 60t
                    present_next = (h100_reg >= t41_reg) && (h100_reg < t60_reg);
                    high_next    = '0;
                    low_next     = '0;
                end else begin
                    present_next = 1'b0;
                end
            end
            KIND_PORT: begin
                pb_new      = (port_b_reg & ~pmask_reg) | (pdata_reg & pmask_reg);
                port_b_next = pb_new;
                restart     = port_b_reg[PB_RESTART] && !pb_new[PB_RESTART];
            end
            default: ;
        endcase
        if (restart) begin
            period_next   = PERIOD_W'(1);
            prescale_next = '0;
            flag_next     = 1'b0;
        end
    end

    assign m_tdata = out_reg;

    // payload capture, products and result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_t'(s_tuser);
            ear_reg   <= s_tdata[0];
            pdata_reg <= s_tdata[8:1];
            pmask_reg <= s_tdata[16:9];
        end
        if (cmd.prod) begin
            h100_reg <= PROD_W'(high_reg) * PROD_W'(100);
            t41_reg  <= PROD_W'(total) * PROD_W'(41);
            t60_reg  <= PROD_W'(total) * PROD_W'(60);
            over_reg <= (total > TOTAL_W'(thresh));
        end
        if (cmd.exec) begin
            out_reg <= {2'b00, port_b_next[PB_REWIND], port_b_next[PB_MOTOR],
                        present_next, flag_next, toggle_next, !toggle_next};
        end
    end

    // configuration registers and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RST;
            period_cfg_reg <= PERIOD_RST;
            factor_reg     <= FACTOR_RST;
            port_b_reg     <= PORT_B_RST;
            last_ear_reg   <= 1'b0;
            toggle_reg     <= 1'b0;
            parity_reg     <= 1'b0;
            seen_reg       <= 1'b0;
            since_reg      <= '0;
            prescale_reg   <= '0;
            period_reg     <= '0;
            flag_reg       <= 1'b0;
            high_reg       <= '0;
            low_reg        <= '0;
            present_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_TIMEOUT: timeout_reg    <= cfg_data;
                    REG_PERIOD:  period_cfg_reg <= cfg_data;
                    REG_FACTOR:  factor_reg     <= cfg_data[FACTOR_W-1:0];
                    REG_NONE:    ;
                    default:     ;
                endcase
            end
            if (cmd.exec) begin
                port_b_reg   <= port_b_next;
                last_ear_reg <= last_ear_next;
                toggle_reg   <= toggle_next;
                parity_reg   <= parity_next;
                seen_reg     <= seen_next;
                since_reg    <= since_next;
                prescale_reg <= prescale_next;
                period_reg   <= period_next;
                flag_reg     <= flag_next;
                high_reg     <= high_next;
                low_reg      <= low_next;
                present_reg  <= present_next;
            end
        end
    end

endmodule

@@ rtl/cassette_pulse_front_end_top.sv @@
// top level of the cassette pulse front end: controller plus datapath
//
//  channel  | direction | beat carries
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tuser: kind; tdata: ear_level, port_data, port_mask
//  m_       | out       | tdata: sid, rst5, count_flag, signal_present, motor, rewind
//  cfg_     | in        | cfg_index, cfg_data (always ready)
//
//  an input beat passes through capture and update, a frame strobe through capture,
//  product and update: the product step registers the duty products 100h, 41t and 60t
//  the update waits while a finished result still sits unaccepted on m_
//  synchronous active-low reset puts configuration and state registers to their defaults, port b to all ones
module cassette_pulse_front_end_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] ear_level, [8:1] port_data, [16:9] port_mask, rest zero
    input  logic [cpfe_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [cpfe_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] sid_level, [1] rst5_level, [2] count_flag, [3] signal_present,
    // [4] motor_on, [5] rewinding, [7:6] zero
    output logic [cpfe_pkg::M_TDATA_W-1:0]  m_tdata,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpfe_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cpfe_pkg::CFG_W-1:0]      cfg_data
);
    import cpfe_pkg::*;

    ctl_cmd_t cmd;

    // register writes are registered directly, so the port never stalls
    assign cfg_ready = 1'b1;

    cpfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cpfe_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

@@ bench/cpfe_tracker_pkg.sv @@
// predicted pin levels and result checking for the cassette pulse front end
package cpfe_tracker_pkg;

    import cpfe_pkg::*;

    class front_end_tracker;

        logic [CNT_W-1:0]    timeout_us;
        logic [CNT_W-1:0]    period_us;
        logic [FACTOR_W-1:0] rewind_factor;

        logic [PORT_W-1:0]   port_b;
        logic                ear_prev;
        logic                toggle;
        logic                parity;
        logic                edge_valid;
        logic [CNT_W-1:0]    silence_us;
        logic [CNT_W-1:0]    prescale;
        logic [PERIOD_W-1:0] step_count;
        logic                flag6;
        logic [CNT_W-1:0]    high_cnt;
        logic [CNT_W-1:0]    low_cnt;
        logic                flag5;

        // expected m_tdata beats, oldest first
        logic [M_TDATA_W-1:0] levels_due[$];
        int faults;

        function new();
            timeout_us    = TIMEOUT_RST;
            period_us     = PERIOD_RST;
            rewind_factor = FACTOR_RST;
            port_b        = PORT_B_RST;
            ear_prev      = 1'b0;
            toggle        = 1'b0;
            parity        = 1'b0;
            edge_valid    = 1'b0;
            silence_us    = '0;
            prescale      = '0;
            step_count    = '0;
            flag6         = 1'b0;
            high_cnt      = '0;
            low_cnt       = '0;
            flag5         = 1'b0;
            faults        = 0;
        endfunction

        function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void restart_steps();
            step_count = 4'd1;
            prescale   = '0;
            flag6      = 1'b0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_TIMEOUT: timeout_us = value;
                REG_PERIOD:  period_us = value;
                REG_FACTOR:  rewind_factor = value[FACTOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_input(kind_t kind, logic ear, logic [PORT_W-1:0] data,
                                 logic [PORT_W-1:0] mask);
            logic              toggle_before;
            logic [PORT_W-1:0] prev_port;
            int unsigned       total;
            int unsigned       limit;
            int unsigned       h100;
            case (kind)
                KIND_EAR: begin
                    toggle_before = toggle;
                    if (ear) high_cnt = bump(high_cnt);
                    else low_cnt = bump(low_cnt);
                    if (!ear_prev && ear) begin
                        if (!edge_valid || silence_us == CNT_MAX || silence_us > timeout_us) begin
                            parity = 1'b0;
                            toggle = 1'b0;
                        end
                        edge_valid = 1'b1;
                        silence_us = '0;
                        parity = ~parity;
                        if (parity) toggle = ~toggle;
                    end
                    ear_prev = ear;
                    if (!toggle_before && toggle && step_count >= RESTART_LEVEL) restart_steps();
                end
                KIND_TICK: begin
                    silence_us = bump(silence_us);
                    prescale = bump(prescale);
                    if (prescale >= period_us) begin
                        prescale = '0;
                        flag6 = (step_count >= FLAG_LEVEL);
                        if (step_count != PERIOD_MAX) step_count = step_count + 1'b1;
                    end
                end
                KIND_FRAME: begin
                    total = high_cnt + low_cnt;
                    limit = (port_b[PB_REWIND] ? int'(rewind_factor) : 1) * BASE_THRESH;
                    if (total > limit) begin
                        // floor(100h/t) strictly inside 40..60
                        h100 = 100 * high_cnt;
                        flag5 = (h100 >= 41 * total) && (h100 < 60 * total);
                        high_cnt = '0;
                        low_cnt = '0;
                    end else begin
                        flag5 = 1'b0;
                    end
                end
                default: begin
                    prev_port = port_b;
                    port_b = (port_b & ~mask) | (data & mask);
                    if (prev_port[PB_RESTART] && !port_b[PB_RESTART]) restart_steps();
                end
            endcase
            levels_due.push_back({2'b00, port_b[PB_REWIND], port_b[PB_MOTOR],
                                  flag5, flag6, toggle, ~toggle});
        endfunction

        function void check_levels(logic [M_TDATA_W-1:0] seen);
            logic [M_TDATA_W-1:0] want;
            if (levels_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result beat %b arrived with nothing outstanding", seen);
                return;
            end
            want = levels_due.pop_front();
            if (seen !== want) begin
                faults++;
                if (faults <= 10)
                    $display("result mismatch (expected/actual): sid %b/%b rst5 %b/%b ",
                             want[0], seen[0], want[1], seen[1],
                             "count %b/%b present %b/%b motor %b/%b ",
                             want[2], seen[2], want[3], seen[3], want[4], seen[4],
                             "rewind %b/%b pad %b/%b",
                             want[5], seen[5], want[7:6], seen[7:6]);
            end
        endfunction

    endclass

endpackage

@@ bench/cassette_pulse_front_end_top_tb.sv @@
// self-checking bench for the cassette pulse front end top level
module cassette_pulse_front_end_top_tb;

    import cpfe_pkg::*;
    import cpfe_tracker_pkg::*;

    // cycles with no beat on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // length of the one long receiver hold-off
    localparam int LONG_HOLD   = 300;
    // length of each unbroken run of ticks, high samples and low samples
    localparam int SOAK_BEATS  = 24;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // shared between stimulus and receiver
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    front_end_tracker pins = new();

    cassette_pulse_front_end_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // idle length for either side: mostly none, some short, a few long
    function automatic int idle_gap();
        if (!idle_on) return 0;
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one input beat, wait for it to be taken, then maybe idle
    // valid stays high across back-to-back beats
    task automatic send_beat(input kind_t kind, input logic ear,
                             input logic [PORT_W-1:0] data, input logic [PORT_W-1:0] mask);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, mask, data, ear};
        do @(posedge aclk); while (!s_tready);
        pins.take_input(kind, ear, data, mask);
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // a beat whose data and mask fields carry random values, which the block must ignore unless it is a port write
    task automatic send_noisy(input kind_t kind, input logic ear);
        send_beat(kind, ear, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // register write beat, valid dropped for one cycle afterwards
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        pins.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // all three registers, the factor with junk in the unused upper byte
    task automatic load_setup(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] period,
                              input logic [FACTOR_W-1:0] factor);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_PERIOD, period);
        write_reg(REG_FACTOR, {8'($urandom_range(0, 255)), factor});
    endtask

    // wait for every outstanding result, then let the pipeline drain
    task automatic settle(input int extra);
        while (pins.levels_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // tape-like traffic: a square-ish carrier on the ear line interleaved with
    // microsecond ticks, with frame strobes, port b writes, silences and glitches
    task automatic play_random(input int beats);
        int    n;
        int    r;
        int    run_left;
        int    hi_len;
        int    lo_len;
        int    burst;
        logic  level;
        kind_t kind;
        logic  ear;
        n        = 0;
        level    = 1'b0;
        hi_len   = 3;
        lo_len   = 3;
        run_left = 3;
        while (n < beats) begin
            r   = $urandom_range(0, 99);
            ear = 1'($urandom_range(0, 1));
            if (r < 42) begin
                kind = KIND_EAR;
                ear  = level;
                run_left--;
                if (run_left <= 0) begin
                    level = ~level;
                    if (level) begin
                        // mostly balanced duty so that the present flag can set
                        hi_len = $urandom_range(1, 5);
                        if ($urandom_range(0, 3) != 0) lo_len = hi_len;
                        else lo_len = $urandom_range(1, 8);
                    end
                    run_left = level ? hi_len : lo_len;
                end
            end else if (r < 80) begin
                kind = KIND_TICK;
            end else if (r < 88) begin
                kind = KIND_FRAME;
            end else if (r < 94) begin
                kind = KIND_PORT;
            end else if (r < 97) begin
                // silence long enough to pass small timeouts
                kind  = KIND_TICK;
                burst = $urandom_range(5, 70);
                repeat (burst) send_noisy(KIND_TICK, 1'($urandom_range(0, 1)));
                n += burst;
            end else begin
                // glitch on the ear line
                kind = KIND_EAR;
            end
            send_noisy(kind, ear);
            n++;
        end
    endtask

    // receiver: checks every result beat and paces m_tready
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) pins.check_levels(m_tdata);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                // long hold-off so the block fills and back-pressures its input
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready  <= 1'b0;
            end else begin
                stall_left = idle_gap();
                m_tready  <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // watchdog on cycles with no beat anywhere
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings
        send_beat(KIND_FRAME, 1'b0, 8'h00, 8'h00);     // frame with no samples
        send_beat(KIND_PORT,  1'b0, 8'h00, 8'h10);     // pb4 falls: counter restart
        send_beat(KIND_PORT,  1'b0, 8'ha5, 8'h00);     // empty mask changes nothing
        send_beat(KIND_EAR,   1'b1, 8'h00, 8'h00);     // first rising edge ever
        send_beat(KIND_EAR,   1'b1, 8'hff, 8'hff);     // level held, unused fields set
        send_beat(KIND_EAR,   1'b0, 8'h00, 8'h00);
        send_beat(KIND_EAR,   1'b1, 8'h00, 8'h00);     // even edge, toggle held
        send_beat(KIND_EAR,   1'b0, 8'h00, 8'h00);
        send_beat(KIND_EAR,   1'b1, 8'h00, 8'h00);     // odd edge, toggle flips
        send_beat(KIND_TICK,  1'b1, 8'hff, 8'hff);     // tick ignores ear and port fields
        send_beat(KIND_PORT,  1'b0, 8'h3f, 8'hff);     // motor and rewind off, pb4 rises
        send_beat(KIND_PORT,  1'b1, 8'hc0, 8'hc0);     // motor and rewind on
        send_beat(KIND_FRAME, 1'b1, 8'hff, 8'hff);     // rewind threshold not reached
        s_tvalid <= 1'b0;
        settle(4);

        // lowest settings: zero period, zero factor, plus a write to an unused index
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_PERIOD, 16'd0);
        write_reg(REG_FACTOR, 16'h0000);
        write_reg(REG_NONE, 16'hffff);
        send_beat(KIND_TICK,  1'b0, 8'h00, 8'h00);     // zero period steps every tick
        send_beat(KIND_TICK,  1'b0, 8'h00, 8'h00);
        send_beat(KIND_TICK,  1'b0, 8'h00, 8'h00);
        send_beat(KIND_EAR,   1'b0, 8'h00, 8'h00);
        send_beat(KIND_EAR,   1'b1, 8'h00, 8'h00);     // edge after silence past timeout
        send_beat(KIND_FRAME, 1'b0, 8'h00, 8'h00);     // zero threshold, any sample counts
        send_beat(KIND_PORT,  1'b0, 8'h00, 8'hff);     // everything low, pb4 falls
        s_tvalid <= 1'b0;
        settle(4);

        // unbroken runs without idling: silence, then high and low sample runs
        load_setup(16'hffff, 16'hffff, 8'hff);
        idle_on = 1'b0;
        repeat (SOAK_BEATS) send_noisy(KIND_TICK, 1'($urandom_range(0, 1)));
        send_noisy(KIND_EAR, 1'b1);                    // ear still high from before the ticks, so no new edge
        repeat (SOAK_BEATS) send_noisy(KIND_EAR, 1'b1);
        repeat (SOAK_BEATS) send_noisy(KIND_EAR, 1'b0);
        send_beat(KIND_PORT, 1'b0, 8'h80, 8'h80);      // rewind on for the big threshold
        send_noisy(KIND_FRAME, 1'b0);
        s_tvalid <= 1'b0;
        idle_on = 1'b1;
        settle(4);

        // random traffic under several settings, extremes first
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_setup(16'd1, 16'd1, 8'd1);
                1: load_setup(16'hffff, 16'hffff, 8'hff);
                default: load_setup(16'($urandom_range(3, 50)), 16'($urandom_range(1, 10)),
                                    8'($urandom_range(1, 4)));
            endcase
            idle_on = (phase != 4);
            if (phase == 3) hold_req = 1'b1;
            play_random(192);
            s_tvalid <= 1'b0;
            settle(4);
        end

        idle_on = 1'b1;
        settle(10);
        if (pins.faults == 0 && pins.levels_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cpfe_pkg.sv
rtl/cpfe_ctrl.sv
rtl/cpfe_datapath.sv
rtl/cassette_pulse_front_end_top.sv
bench/cpfe_tracker_pkg.sv
bench/cassette_pulse_front_end_top_tb.sv
